// ----- rtl/isrt_pkg.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter package
// Word type, cell control struct and sequencer states shared by the sorter.
// ----------------------------------------------------------------------------
package isrt_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } isrt_ctrl_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

endpackage

// ----- rtl/isrt_in_if.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter input channel
// Valid/ready channel that carries one element of a set and its last flag.
// ----------------------------------------------------------------------------
interface isrt_in_if
  import isrt_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t value;
  logic  last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink (input valid, input value, input last_in, output ready);
endinterface

// ----- rtl/isrt_out_if.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter output channel
// Valid/ready channel that carries one sorted element with its flags.
// ----------------------------------------------------------------------------
interface isrt_out_if
  import isrt_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

// ----- rtl/insertion_sorter.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter
// Stable ascending signed sort of a framed set, built as a row of cells.
//
//   Channel  Direction  Payload                               Transfer when
//   feed     in         value, last_in                        valid && ready
//   result   out        sorted_value, last_out, overflow      valid && ready
//
// An element is inserted into the cell row in the cycle of its transfer, so
// the feed side takes one element per cycle while a set is being collected.
// After the transfer marked last_in the row drains from its lowest cell, one
// result per cycle while result.ready is high; feed.ready is low meanwhile.
// Elements that arrive with the row full are dropped. Reset empties the row
// and clears the overflow flag.
// ----------------------------------------------------------------------------
module insertion_sorter
  import isrt_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic          clk,
  input  logic          rst,
  isrt_in_if.sink       feed,
  isrt_out_if.source    result
);

  state_t                 state;
  state_t                 state_next;
  isrt_ctrl_t             ctrl;
  logic                   dropped;
  logic                   full;
  logic                   feed_xfer;
  logic                   result_xfer;
  word_t                  cell_data  [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]   cell_valid;
  logic [MAX_ITEMS-1:0]   cell_gt;

  assign full        = cell_valid[MAX_ITEMS-1];
  assign feed_xfer   = feed.valid && feed.ready;
  assign result_xfer = result.valid && result.ready;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isrt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_value  (feed.value),
      .prev_data  ((i == 0) ? word_t'('0) : cell_data[(i == 0) ? 0 : i-1]),
      .prev_valid ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
      .prev_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i-1]),
      .next_data  ((i == MAX_ITEMS-1) ? word_t'('0)
                                      : cell_data[(i == MAX_ITEMS-1) ? i : i+1]),
      .next_valid ((i == MAX_ITEMS-1) ? 1'b0
                                      : cell_valid[(i == MAX_ITEMS-1) ? i : i+1]),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .gt         (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (feed_xfer && full) begin
      dropped <= 1'b1;
    end else if (result_xfer && result.last_out) begin
      dropped <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (feed_xfer && feed.last_in) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (result_xfer && result.last_out) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_comb begin
    feed.ready   = 1'b0;
    result.valid = 1'b0;
    ctrl.insert  = 1'b0;
    ctrl.shift   = 1'b0;
    unique case (state)
      ST_FILL: begin
        feed.ready  = 1'b1;
        ctrl.insert = feed.valid && !full;
      end
      ST_DRAIN: begin
        result.valid = 1'b1;
        ctrl.shift   = result.ready;
      end
      default: begin
        feed.ready = 1'b0;
      end
    endcase
  end

  assign result.sorted_value = cell_data[0];
  assign result.last_out     = !cell_valid[1];
  assign result.overflow     = dropped;

`ifndef SYNTHESIS
  // Occupied cells always form an unbroken run from the lowest cell.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("cell row has a gap");

  // A drain always has an element to present.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> cell_valid[0])
    else $error("drain with empty row");

  // The final transfer of a set leaves the row empty and the flag clear.
  a_empty_after_set: assert property (@(posedge clk) disable iff (rst)
    (result_xfer && result.last_out) |=> (cell_valid == '0) && !dropped)
    else $error("row not emptied after set");

  // An accepted element that fits always occupies the lowest cell next cycle.
  a_insert_lands: assert property (@(posedge clk) disable iff (rst)
    (feed_xfer && !full) |=> cell_valid[0])
    else $error("inserted element lost");

  // The overflow flag does not change while a set drains.
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DRAIN) && $past(state == ST_DRAIN)) |-> $stable(result.overflow))
    else $error("overflow changed during drain");
`endif

endmodule

// ----- rtl/isrt_cell.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter cell
// Holds one element of the sorted row. On insert it keeps its element, takes
// the new element or takes its lower neighbour's element; on shift it takes
// its upper neighbour's element.
// ----------------------------------------------------------------------------
module isrt_cell
  import isrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  isrt_ctrl_t ctrl,
  input  word_t      new_value,
  input  word_t      prev_data,
  input  logic       prev_valid,
  input  logic       prev_gt,
  input  word_t      next_data,
  input  logic       next_valid,
  output word_t      data,
  output logic       valid,
  output logic       gt
);

  assign gt = valid && (data > new_value);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (prev_gt) begin
        data <= prev_data;
      end else if (gt || (!valid && prev_valid)) begin
        data <= new_value;
      end
    end else if (ctrl.shift) begin
      data <= next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (prev_gt || gt || (!valid && prev_valid)) begin
        valid <= 1'b1;
      end
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end
  end

endmodule

// ----- tb/isrt_sort_checker.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter checker
// Watches both channels of the sorter and keeps its own ordered copy of the
// current set. When the final element of a set arrives it lists the set in
// stable ascending signed order, and it compares every result transfer with
// the oldest listed element, field by field.
// ----------------------------------------------------------------------------
module isrt_sort_checker
  import isrt_pkg::*;
#(
  parameter int MAX_ITEMS = 16
) (
  input  logic clk,
  input  logic rst,
  isrt_in_if   feed,
  isrt_out_if  result,
  output int   errors,
  output int   pending,
  output int   sets_closed,
  output int   results_checked,
  output int   overflow_sets
);

  typedef struct {
    word_t sorted_value;
    logic  last_out;
    logic  overflow;
  } sorted_elem_t;

  word_t        held_set[$];
  logic         dropped;
  sorted_elem_t sorted_due[$];

  initial begin
    errors          = 0;
    pending         = 0;
    sets_closed     = 0;
    results_checked = 0;
    overflow_sets   = 0;
    dropped         = 1'b0;
  end

  function automatic void absorb_element(input word_t v);
    int pos;
    if (held_set.size() < MAX_ITEMS) begin
      pos = held_set.size();
      while (pos > 0 && held_set[pos-1] > v) pos--;
      held_set.insert(pos, v);
    end else begin
      dropped = 1'b1;
    end
  endfunction

  function automatic void close_set();
    sorted_elem_t e;
    for (int k = 0; k < held_set.size(); k++) begin
      e.sorted_value = held_set[k];
      e.last_out     = (k == held_set.size() - 1);
      e.overflow     = dropped;
      sorted_due.push_back(e);
    end
    if (dropped) overflow_sets++;
    sets_closed++;
    held_set.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    sorted_elem_t want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (sorted_due.size() == 0) begin
          $display("%0t unexpected result: expected none, actual value %0d last %0b ovf %0b",
                   $time, result.sorted_value, result.last_out, result.overflow);
          errors++;
        end else begin
          want = sorted_due.pop_front();
          results_checked++;
          if (result.sorted_value !== want.sorted_value) begin
            $display("%0t sorted_value mismatch: expected %0d actual %0d",
                     $time, want.sorted_value, result.sorted_value);
            errors++;
          end
          if (result.last_out !== want.last_out) begin
            $display("%0t last_out mismatch: expected %0b actual %0b",
                     $time, want.last_out, result.last_out);
            errors++;
          end
          if (result.overflow !== want.overflow) begin
            $display("%0t overflow mismatch: expected %0b actual %0b",
                     $time, want.overflow, result.overflow);
            errors++;
          end
        end
      end
      if (feed.valid && feed.ready) begin
        absorb_element(feed.value);
        if (feed.last_in) close_set();
      end
    end
    pending <= sorted_due.size();
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Insertion sorter testbench
// Feeds framed sets to the sorter, directed corner cases first and then random
// sets under three patterns of idling on both channels, with one long stall of
// the result side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb
  import isrt_pkg::*;
;

  localparam int    MAX_ITEMS   = 16;
  localparam int    HOLD_CYCLES = 200;
  localparam int    LIMIT       = 200000;
  localparam int    TAIL_CYCLES = 2 * MAX_ITEMS + 8;
  localparam word_t WORD_MIN    = 32'sh8000_0000;
  localparam word_t WORD_MAX    = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isrt_in_if  feed ();
  isrt_out_if result ();

  int   errors;
  int   pending;
  int   sets_closed;
  int   results_checked;
  int   overflow_sets;
  int   items_sent = 0;
  int   cycles     = 0;
  int   tx_idle_pct = 29;
  int   rx_idle_pct = 52;
  logic hold_req  = 1'b0;
  logic rx_hold   = 1'b0;

  insertion_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .result (result)
  );

  isrt_sort_checker #(.MAX_ITEMS(MAX_ITEMS)) u_check (
    .clk             (clk),
    .rst             (rst),
    .feed            (feed),
    .result          (result),
    .errors          (errors),
    .pending         (pending),
    .sets_closed     (sets_closed),
    .results_checked (results_checked),
    .overflow_sets   (overflow_sets)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    result.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    wait (hold_req);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_item(input word_t v, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      feed.valid <= 1'b0;
      @(posedge clk);
    end
    feed.valid   <= 1'b1;
    feed.value   <= v;
    feed.last_in <= last;
    @(posedge clk);
    while (!feed.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    feed.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic word_t pick_value();
    case ($urandom_range(7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2, 3:    return word_t'($urandom_range(8)) - 4;
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic run_sets(input int item_goal);
    int len;
    int stop_at;
    stop_at = items_sent + item_goal;
    while (items_sent < stop_at) begin
      case ($urandom_range(7))
        0:       len = MAX_ITEMS;
        1:       len = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS + 1);
        default: len = $urandom_range(MAX_ITEMS, 1);
      endcase
      for (int i = 0; i < len; i++) send_item(pick_value(), i == len - 1);
    end
  endtask

  initial begin
    feed.valid   <= 1'b0;
    feed.value   <= '0;
    feed.last_in <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(WORD_MIN, 1'b1);

    send_item(WORD_MAX, 1'b0);
    send_item(WORD_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(5, 1'b0);
    send_item(5, 1'b0);
    send_item(1, 1'b1);

    for (int i = 0; i < MAX_ITEMS + 1; i++) begin
      case (i % 4)
        0:       send_item(WORD_MAX - i, i == MAX_ITEMS);
        1:       send_item(WORD_MIN + i, i == MAX_ITEMS);
        default: send_item(word_t'(i % 3), i == MAX_ITEMS);
      endcase
    end
    wait_drained();

    run_sets(130);
    wait_drained();

    tx_idle_pct <= 52;
    rx_idle_pct <= 29;
    run_sets(135);
    wait_drained();

    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    run_sets(135);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d elements in %0d sets, %0d of them past capacity.",
             items_sent, sets_closed, overflow_sets);
    $display("Compared %0d sorted results under three idling patterns and a long stall.",
             results_checked);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
